// ===== hw/rtl/tfn_pkg.sv =====
// tfn_pkg: constants, payload types and job type for the triangle face normal block
// no dependencies; every other file in hw/rtl refers to it by scoped names
package tfn_pkg;

   // store geometry
   localparam int VERTEX_SLOTS = 4096;
   localparam int COORD_BITS   = 32;
   localparam int SLOT_BITS    = $clog2(VERTEX_SLOTS);

   // front to back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // command codes
   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_TRIANGLE = 1'b1;

   // fixed point constants
   localparam logic [15:0] Q14_ONE       = 16'd16384;
   localparam logic [15:0] ALB_DEFAULT_R = 16'd23593;
   localparam logic [15:0] ALB_DEFAULT_G = 16'd22938;
   localparam logic [15:0] ALB_DEFAULT_B = 16'd21627;
   // ceil(2^31 / 255): byte/255 by reciprocal, exact for 23-bit numerators
   localparam logic [23:0] RECIP_255     = 24'd8421505;
   localparam int          RECIP_SHIFT   = 31;
   localparam logic [22:0] ALB_ROUND     = 23'd127;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vertex_type;

   typedef struct packed {
      logic               command;
      logic [11:0]        load_slot;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [11:0]        corner_a;
      logic [11:0]        corner_b;
      logic [11:0]        corner_c;
      logic [7:0]         tint_red;
      logic [7:0]         tint_green;
      logic [7:0]         tint_blue;
   } req_item_type;

   typedef struct packed {
      logic [15:0]        albedo_red;
      logic [15:0]        albedo_green;
      logic [15:0]        albedo_blue;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               degenerate;
   } rsp_item_type;

   // one triangle with its three vertices fetched
   typedef struct packed {
      vertex_type va;
      vertex_type vb;
      vertex_type vc;
      logic [7:0] tint_red;
      logic [7:0] tint_green;
      logic [7:0] tint_blue;
   } job_type;

endpackage

// ===== hw/rtl/tfn_if.sv =====
// tfn_req_if and tfn_rsp_if: valid/ready channels for requests and responses
// depends on tfn_pkg for the payload types
interface tfn_req_if;
   logic                  valid;
   logic                  ready;
   tfn_pkg::req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tfn_rsp_if;
   logic                  valid;
   logic                  ready;
   tfn_pkg::rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/tfn_front.sv =====
// tfn_front: accepts request transactions, holds the vertex store, fetches corners
// depends on tfn_pkg and tfn_req_if
module tfn_front (
   input  logic              clock,
   input  logic              reset,
   tfn_req_if.sink           req_port,
   output logic              job_valid,
   input  logic              job_ready,
   output tfn_pkg::job_type  job
);

   typedef enum logic [2:0] {
      F_IDLE, F_RA, F_RB, F_RC, F_CAP, F_PUSH
   } fstate_type;

   fstate_type state_ff;
   logic [11:0] corner_a_ff, corner_b_ff, corner_c_ff;
   tfn_pkg::job_type job_ff;

   logic [3*tfn_pkg::COORD_BITS-1:0] mem [tfn_pkg::VERTEX_SLOTS];
   logic [3*tfn_pkg::COORD_BITS-1:0] rd_ff;
   logic                             rd_ok_ff;

   logic        accept;
   logic [11:0] rd_slot;
   tfn_pkg::vertex_type rd_vertex;

   function automatic logic in_range(input logic [11:0] slot);
      return 32'(slot) < 32'(tfn_pkg::VERTEX_SLOTS);
   endfunction

   assign req_port.ready = (state_ff == F_IDLE);
   assign accept         = req_port.valid && req_port.ready;
   assign job_valid      = (state_ff == F_PUSH);
   assign job            = job_ff;

   always_comb begin
      unique case (state_ff)
         F_RB:    rd_slot = corner_b_ff;
         F_RC:    rd_slot = corner_c_ff;
         default: rd_slot = corner_a_ff;
      endcase
   end

   // out-of-range corners read as the origin
   assign rd_vertex = rd_ok_ff ? tfn_pkg::vertex_type'(rd_ff) : '0;

   always_ff @(posedge clock) begin
      if (accept && req_port.payload.command == tfn_pkg::CMD_LOAD &&
          in_range(req_port.payload.load_slot)) begin
         mem[tfn_pkg::SLOT_BITS'(req_port.payload.load_slot)] <= {
            req_port.payload.pos_x[tfn_pkg::COORD_BITS-1:0],
            req_port.payload.pos_y[tfn_pkg::COORD_BITS-1:0],
            req_port.payload.pos_z[tfn_pkg::COORD_BITS-1:0]};
      end
      rd_ff    <= mem[tfn_pkg::SLOT_BITS'(rd_slot)];
      rd_ok_ff <= in_range(rd_slot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (accept && req_port.payload.command == tfn_pkg::CMD_TRIANGLE) begin
                  corner_a_ff       <= req_port.payload.corner_a;
                  corner_b_ff       <= req_port.payload.corner_b;
                  corner_c_ff       <= req_port.payload.corner_c;
                  job_ff.tint_red   <= req_port.payload.tint_red;
                  job_ff.tint_green <= req_port.payload.tint_green;
                  job_ff.tint_blue  <= req_port.payload.tint_blue;
                  state_ff          <= F_RA;
               end
            end
            F_RA: state_ff <= F_RB;
            F_RB: begin
               job_ff.va <= rd_vertex;
               state_ff  <= F_RC;
            end
            F_RC: begin
               job_ff.vb <= rd_vertex;
               state_ff  <= F_CAP;
            end
            F_CAP: begin
               job_ff.vc <= rd_vertex;
               state_ff  <= F_PUSH;
            end
            F_PUSH: begin
               if (job_ready) state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   a_tri_blocks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_port.payload.command == tfn_pkg::CMD_TRIANGLE) |=> !req_port.ready)
      else $error("front took a transaction while fetching corners");

endmodule

// ===== hw/rtl/tfn_queue.sv =====
// tfn_queue: short fifo of fetched triangles between front and back
// depends on tfn_pkg
module tfn_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  tfn_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output tfn_pkg::job_type pop_job
);

   tfn_pkg::job_type               entry_ff [tfn_pkg::QUEUE_DEPTH];
   logic [tfn_pkg::QPTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [tfn_pkg::QCNT_BITS-1:0]  count_ff;
   logic                           push, pop;

   assign push_ready = (count_ff != tfn_pkg::QCNT_BITS'(tfn_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         priority if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push)     count_ff <= count_ff - 1'b1;
         else                       count_ff <= count_ff;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tfn_pkg::QCNT_BITS'(tfn_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

// ===== hw/rtl/tfn_back.sv =====
// tfn_back: albedo, cross product, normalisation, square root and division per triangle
// depends on tfn_pkg and tfn_rsp_if
module tfn_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  tfn_pkg::job_type job,
   tfn_rsp_if.source        rsp_port
);

   typedef enum logic [3:0] {
      B_IDLE, B_ALB, B_EDGE, B_HALVE, B_MUL, B_MAG, B_NORM,
      B_SQ, B_SQRT, B_DIVLD, B_DIV, B_DIVST, B_DONE
   } bstate_type;

   bstate_type       state_ff;
   tfn_pkg::job_type job_ff;
   logic [4:0]       cnt_ff;
   logic [1:0]       comp_ff;

   logic [15:0]        alb_ff  [3];
   logic [32:0]        e1m_ff  [3];
   logic [32:0]        e2m_ff  [3];
   logic [2:0]         e1n_ff, e2n_ff;
   logic signed [61:0] prod_ff, acc_ff;
   logic signed [61:0] n_ff    [3];
   logic [2:0]         nneg_ff;
   logic [60:0]        m_ff    [3];
   logic [61:0]        sum_ff, x_ff, r_ff, bit_ff;
   logic [45:0]        rem_ff, d_ff;
   logic [15:0]        q_ff;
   logic signed [15:0] nrm_ff  [3];
   logic               degen_ff;

   tfn_pkg::rsp_item_type out_ff;
   logic                  out_valid_ff;

   logic signed [30:0] mul_a, mul_b;
   logic [1:0]         sel1, sel2;
   logic [60:0]        orv;
   logic [61:0]        trial;
   logic [7:0]         tint;
   logic [46:0]        alb_prod;
   logic [15:0]        q_cap;
   logic               out_load;

   function automatic logic signed [30:0] signed_op(input logic [32:0] mag, input logic neg);
      logic signed [30:0] v;
      v = signed'({1'b0, mag[29:0]});
      return neg ? -v : v;
   endfunction

   function automatic logic [32:0] edge_mag(input tfn_pkg::coord_type p,
                                             input tfn_pkg::coord_type q);
      logic signed [33:0] d;
      d = 34'(p) - 34'(q);
      return d[33] ? 33'(-d) : d[32:0];
   endfunction

   function automatic logic [60:0] abs62(input logic signed [61:0] v);
      return v[61] ? 61'(-v) : v[60:0];
   endfunction

   assign job_ready = (state_ff == B_IDLE);
   assign out_load  = (state_ff == B_DONE) && (!out_valid_ff || rsp_port.ready);
   assign rsp_port.valid   = out_valid_ff;
   assign rsp_port.payload = out_ff;

   // operand pairs of the cross product
   always_comb begin
      unique case (cnt_ff[2:0])
         3'd0:    begin sel1 = 2'd1; sel2 = 2'd2; end
         3'd1:    begin sel1 = 2'd2; sel2 = 2'd1; end
         3'd2:    begin sel1 = 2'd2; sel2 = 2'd0; end
         3'd3:    begin sel1 = 2'd0; sel2 = 2'd2; end
         3'd4:    begin sel1 = 2'd0; sel2 = 2'd1; end
         3'd5:    begin sel1 = 2'd1; sel2 = 2'd0; end
         default: begin sel1 = 2'd0; sel2 = 2'd0; end
      endcase
   end

   always_comb begin
      if (state_ff == B_SQ) begin
         mul_a = signed'({1'b0, m_ff[cnt_ff[1:0] == 2'd3 ? 2'd0 : cnt_ff[1:0]][29:0]});
         mul_b = mul_a;
      end else begin
         mul_a = signed_op(e1m_ff[sel1], e1n_ff[sel1]);
         mul_b = signed_op(e2m_ff[sel2], e2n_ff[sel2]);
      end
   end

   assign orv   = m_ff[0] | m_ff[1] | m_ff[2];
   assign trial = r_ff + bit_ff;

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    tint = job_ff.tint_red;
         2'd1:    tint = job_ff.tint_green;
         default: tint = job_ff.tint_blue;
      endcase
   end
   assign alb_prod = 47'({tint, 15'd0} + 23'(tfn_pkg::ALB_ROUND)) * 47'(tfn_pkg::RECIP_255);
   assign q_cap    = (q_ff > tfn_pkg::Q14_ONE) ? tfn_pkg::Q14_ONE : q_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load)                            out_valid_ff <= 1'b1;
         else if (rsp_port.ready && out_valid_ff) out_valid_ff <= 1'b0;

         unique case (state_ff)
            B_IDLE: begin
               if (job_valid) begin
                  job_ff   <= job;
                  cnt_ff   <= '0;
                  state_ff <= B_ALB;
               end
            end
            B_ALB: begin
               if ((job_ff.tint_red | job_ff.tint_green | job_ff.tint_blue) == 8'd0) begin
                  alb_ff[0] <= tfn_pkg::ALB_DEFAULT_R;
                  alb_ff[1] <= tfn_pkg::ALB_DEFAULT_G;
                  alb_ff[2] <= tfn_pkg::ALB_DEFAULT_B;
                  state_ff  <= B_EDGE;
               end else begin
                  alb_ff[cnt_ff[1:0]] <= alb_prod[tfn_pkg::RECIP_SHIFT +: 16];
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == 5'd2) state_ff <= B_EDGE;
               end
            end
            B_EDGE: begin
               e1m_ff[0] <= edge_mag(job_ff.vb.x, job_ff.va.x);
               e1m_ff[1] <= edge_mag(job_ff.vb.y, job_ff.va.y);
               e1m_ff[2] <= edge_mag(job_ff.vb.z, job_ff.va.z);
               e2m_ff[0] <= edge_mag(job_ff.vc.x, job_ff.va.x);
               e2m_ff[1] <= edge_mag(job_ff.vc.y, job_ff.va.y);
               e2m_ff[2] <= edge_mag(job_ff.vc.z, job_ff.va.z);
               e1n_ff    <= {34'(job_ff.vb.z) < 34'(job_ff.va.z),
                             34'(job_ff.vb.y) < 34'(job_ff.va.y),
                             34'(job_ff.vb.x) < 34'(job_ff.va.x)};
               e2n_ff    <= {34'(job_ff.vc.z) < 34'(job_ff.va.z),
                             34'(job_ff.vc.y) < 34'(job_ff.va.y),
                             34'(job_ff.vc.x) < 34'(job_ff.va.x)};
               degen_ff  <= 1'b0;
               state_ff  <= B_HALVE;
            end
            B_HALVE: begin
               // halve every edge until all magnitudes sit below 2^30
               if (|{e1m_ff[0][32:30], e1m_ff[1][32:30], e1m_ff[2][32:30],
                     e2m_ff[0][32:30], e2m_ff[1][32:30], e2m_ff[2][32:30]}) begin
                  for (int i = 0; i < 3; i++) begin
                     e1m_ff[i] <= e1m_ff[i] >> 1;
                     e2m_ff[i] <= e2m_ff[i] >> 1;
                  end
               end else begin
                  cnt_ff   <= '0;
                  state_ff <= B_MUL;
               end
            end
            B_MUL: begin
               // prod_ff holds the product issued in the previous cycle
               if (cnt_ff != 5'd0) begin
                  if (cnt_ff[0]) acc_ff <= prod_ff;
                  else           n_ff[2'(cnt_ff[2:1] - 2'd1)] <= acc_ff - prod_ff;
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd6) state_ff <= B_MAG;
            end
            B_MAG: begin
               for (int i = 0; i < 3; i++) begin
                  nneg_ff[i] <= n_ff[i][61];
                  m_ff[i]    <= abs62(n_ff[i]);
               end
               state_ff <= B_NORM;
            end
            B_NORM: begin
               priority if (orv == '0) begin
                  nrm_ff[0] <= '0;
                  nrm_ff[1] <= '0;
                  nrm_ff[2] <= signed'(tfn_pkg::Q14_ONE);
                  degen_ff  <= 1'b1;
                  state_ff  <= B_DONE;
               end else if (|orv[60:34]) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 4;
               end else if (|orv[60:30]) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 1;
               end else if (orv[29:25] == 5'd0) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 4;
               end else if (!orv[29]) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 1;
               end else begin
                  sum_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= B_SQ;
               end
            end
            B_SQ: begin
               if (cnt_ff == 5'd3) begin
                  x_ff     <= sum_ff + prod_ff;
                  r_ff     <= '0;
                  bit_ff   <= 62'(1) << 60;
                  cnt_ff   <= '0;
                  state_ff <= B_SQRT;
               end else begin
                  if (cnt_ff != 5'd0) sum_ff <= sum_ff + prod_ff;
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            B_SQRT: begin
               // one root bit per cycle
               if (x_ff >= trial) begin
                  x_ff <= x_ff - trial;
                  r_ff <= (r_ff >> 1) + bit_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd30) begin
                  comp_ff  <= '0;
                  state_ff <= B_DIVLD;
               end
            end
            B_DIVLD: begin
               rem_ff   <= 46'({m_ff[comp_ff][29:0], 14'd0}) + 46'(r_ff[30:1]);
               d_ff     <= {r_ff[30:0], 15'd0};
               q_ff     <= '0;
               cnt_ff   <= '0;
               state_ff <= B_DIV;
            end
            B_DIV: begin
               if (rem_ff >= d_ff) begin
                  rem_ff <= rem_ff - d_ff;
                  q_ff   <= {q_ff[14:0], 1'b1};
               end else begin
                  q_ff   <= {q_ff[14:0], 1'b0};
               end
               d_ff   <= d_ff >> 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd15) state_ff <= B_DIVST;
            end
            B_DIVST: begin
               nrm_ff[comp_ff] <= nneg_ff[comp_ff] ? -signed'(q_cap) : signed'(q_cap);
               if (comp_ff == 2'd2) begin
                  state_ff <= B_DONE;
               end else begin
                  comp_ff  <= comp_ff + 1'b1;
                  state_ff <= B_DIVLD;
               end
            end
            B_DONE: begin
               if (out_load) begin
                  out_ff.albedo_red   <= alb_ff[0];
                  out_ff.albedo_green <= alb_ff[1];
                  out_ff.albedo_blue  <= alb_ff[2];
                  out_ff.normal_x     <= nrm_ff[0];
                  out_ff.normal_y     <= nrm_ff[1];
                  out_ff.normal_z     <= nrm_ff[2];
                  out_ff.degenerate   <= degen_ff;
                  state_ff            <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   a_degen_normal: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.degenerate) |->
         (out_ff.normal_x == 16'sd0 && out_ff.normal_y == 16'sd0 &&
          out_ff.normal_z == 16'sd16384))
      else $error("degenerate result without default normal");

   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.normal_x <= 16'sd16384 && out_ff.normal_x >= -16'sd16384 &&
                        out_ff.normal_y <= 16'sd16384 && out_ff.normal_y >= -16'sd16384 &&
                        out_ff.normal_z <= 16'sd16384 && out_ff.normal_z >= -16'sd16384))
      else $error("normal component beyond unit range");

endmodule

// ===== hw/rtl/triangle_face_normal_albedo.sv =====
// triangle_face_normal_albedo: top level joining front, queue and back
// depends on tfn_pkg, tfn_if, tfn_front, tfn_queue and tfn_back
//
// A load transaction (command 0) writes one Q16.16 vertex into the 4096-slot
// vertex store and gives no response. A triangle transaction (command 1) names
// three slots and carries colour bytes, and gives exactly one response: the unit
// normal of (b-a) x (c-a) in Q1.14 and the albedo colour/255 in Q1.15 (default
// grey when all bytes are zero). A slot must be loaded before a triangle reads
// it. The front reads the three corners through the single store port in states
// F_RA, F_RB, F_RC and F_CAP and offers the triangle to a two-entry queue in
// F_PUSH; it takes no transaction until the queue has taken the triangle, which
// waits while the queue is full. The back works one triangle at a time, through
// the one-bit-a-cycle square root and the three restoring divisions, plus a
// shared 31x31 multiplier for the cross and square terms, edge halving and
// result scaling. A flat triangle skips the root and divisions. Loads interleave
// freely while the queue has room. The response sits in an output register, so
// the back starts the next triangle while the sink stalls.
module triangle_face_normal_albedo (
   input logic        clock,
   input logic        reset,
   tfn_req_if.sink    req_chan,
   tfn_rsp_if.source  rsp_chan
);

   // front to queue
   logic             fq_valid, fq_ready;
   tfn_pkg::job_type fq_job;

   // queue to back
   logic             qb_valid, qb_ready;
   tfn_pkg::job_type qb_job;

   // store, request acceptance and corner fetch
   tfn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_chan),
      .job_valid (fq_valid),
      .job_ready (fq_ready),
      .job       (fq_job)
   );

   // decouples fetching from the long arithmetic
   tfn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_job   (fq_job),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_job    (qb_job)
   );

   // normal and albedo arithmetic, registered response
   tfn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job       (qb_job),
      .rsp_port  (rsp_chan)
   );

endmodule

// ===== sim/testbench.sv =====
// testbench: self-checking bench for triangle_face_normal_albedo
// depends on tfn_pkg, tfn_if and the block itself; predicts normals and albedo in-bench
module testbench;
   import tfn_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int STALL_LIMIT  = 20000;
   localparam int LONG_HOLD    = 1000;

   typedef struct {
      req_item_type item;
      bit           drain_first;
   } pending_type;

   logic clock;
   logic reset;

   tfn_req_if req_chan ();
   tfn_rsp_if rsp_chan ();

   triangle_face_normal_albedo i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // bench-side copy of the vertex store
   vertex_type   vertex_mem [VERTEX_SLOTS];
   pending_type  pending [$];
   rsp_item_type expected_faces [$];
   int           loaded_slots [$];
   bit           slot_loaded [VERTEX_SLOTS];

   int total_items;
   int items_in;
   int loads_in;
   int triangles_in;
   int faces_out;
   int degenerate_out;
   int default_albedo_out;
   int mismatches;
   int idle_cycles;
   int hold_left;
   bit long_hold_done;

   // clock and the single reset pulse
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic longint unsigned mag_of(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   function automatic longint halve_of(longint v);
      longint unsigned m;
      m = mag_of(v) >> 1;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [15:0] albedo_of(logic [7:0] b);
      int unsigned num;
      num = b * 32768 + 127;
      return 16'(num / 255);
   endfunction

   // expected response of one triangle transaction
   function automatic rsp_item_type shade_triangle(vertex_type a, vertex_type b,
                                                    vertex_type c, logic [7:0] r,
                                                    logic [7:0] g, logic [7:0] bl);
      rsp_item_type res;
      longint e1 [3];
      longint e2 [3];
      longint n [3];
      longint unsigned m [3];
      longint unsigned big, len, sum, bitv, q;
      logic [15:0] nrm [3];
      int i;
      e1[0] = longint'(b.x) - longint'(a.x);
      e1[1] = longint'(b.y) - longint'(a.y);
      e1[2] = longint'(b.z) - longint'(a.z);
      e2[0] = longint'(c.x) - longint'(a.x);
      e2[1] = longint'(c.y) - longint'(a.y);
      e2[2] = longint'(c.z) - longint'(a.z);
      // halve both edges until every component fits below 2^30
      forever begin
         big = 0;
         for (i = 0; i < 3; i++) begin
            if (mag_of(e1[i]) > big) big = mag_of(e1[i]);
            if (mag_of(e2[i]) > big) big = mag_of(e2[i]);
         end
         if (big < (64'd1 << 30)) break;
         for (i = 0; i < 3; i++) begin
            e1[i] = halve_of(e1[i]);
            e2[i] = halve_of(e2[i]);
         end
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      big = 0;
      for (i = 0; i < 3; i++) begin
         m[i] = mag_of(n[i]);
         if (m[i] > big) big = m[i];
      end
      if (big == 0) begin
         nrm[0] = '0;
         nrm[1] = '0;
         nrm[2] = Q14_ONE;
         res.degenerate = 1'b1;
      end else begin
         // bring the largest magnitude into [2^29, 2^30)
         while (big >= (64'd1 << 30)) begin
            for (i = 0; i < 3; i++) m[i] = m[i] >> 1;
            big = big >> 1;
         end
         while (big < (64'd1 << 29)) begin
            for (i = 0; i < 3; i++) m[i] = m[i] << 1;
            big = big << 1;
         end
         sum  = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
         len  = 0;
         bitv = 64'd1 << 62;
         while (bitv > sum) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (sum >= len + bitv) begin
               sum = sum - (len + bitv);
               len = (len >> 1) + bitv;
            end else begin
               len = len >> 1;
            end
            bitv = bitv >> 2;
         end
         for (i = 0; i < 3; i++) begin
            q = (m[i] * 16384 + len / 2) / len;
            if (q > 16384) q = 16384;
            nrm[i] = n[i] < 0 ? 16'(64'd0 - q) : 16'(q);
         end
         res.degenerate = 1'b0;
      end
      res.normal_x = nrm[0];
      res.normal_y = nrm[1];
      res.normal_z = nrm[2];
      if ((r | g | bl) == 8'd0) begin
         res.albedo_red   = ALB_DEFAULT_R;
         res.albedo_green = ALB_DEFAULT_G;
         res.albedo_blue  = ALB_DEFAULT_B;
      end else begin
         res.albedo_red   = albedo_of(r);
         res.albedo_green = albedo_of(g);
         res.albedo_blue  = albedo_of(bl);
      end
      return res;
   endfunction

   // queue a load; unused triangle fields carry noise
   task automatic queue_load(int slot, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             bit drain);
      pending_type p;
      p.item           = req_item_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      p.item.command   = CMD_LOAD;
      p.item.load_slot = 12'(slot);
      p.item.pos_x     = px;
      p.item.pos_y     = py;
      p.item.pos_z     = pz;
      p.drain_first    = drain;
      pending.push_back(p);
      if (!slot_loaded[slot]) begin
         slot_loaded[slot] = 1'b1;
         loaded_slots.push_back(slot);
      end
   endtask

   task automatic queue_triangle(int ca, int cb, int cc, logic [7:0] r, logic [7:0] g,
                                 logic [7:0] bl, bit drain);
      pending_type p;
      p.item            = req_item_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      p.item.command    = CMD_TRIANGLE;
      p.item.corner_a   = 12'(ca);
      p.item.corner_b   = 12'(cb);
      p.item.corner_c   = 12'(cc);
      p.item.tint_red   = r;
      p.item.tint_green = g;
      p.item.tint_blue  = bl;
      p.drain_first     = drain;
      pending.push_back(p);
   endtask

   // mix of small, mid-sized and full-range coordinates
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom;
         4, 5:    return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
         default: return 32'($signed($urandom_range(2 * 65536 * 4)) - 65536 * 4);
      endcase
   endfunction

   function automatic logic [7:0] pick_tint();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic build_stimulus();
      int k, ca, cb, cc;
      bit drain;
      logic [7:0] r, g, bl;
      // directed: corner values, degenerate shapes, default and full albedo
      queue_load(0, 32'd0, 32'd0, 32'd0, 1'b0);
      queue_load(1, 32'h0001_0000, 32'd0, 32'd0, 1'b0);
      queue_load(2, 32'd0, 32'h0001_0000, 32'd0, 1'b0);
      queue_load(3, 32'h0002_0000, 32'd0, 32'd0, 1'b0);
      queue_load(4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      queue_load(12'hAAA, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      queue_load(12'h555, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      queue_load(7, 32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 1'b0);
      queue_triangle(0, 1, 2, 8'd0, 8'd0, 8'd0, 1'b0);
      queue_triangle(0, 1, 2, 8'd255, 8'd255, 8'd255, 1'b0);
      queue_triangle(0, 2, 1, 8'd1, 8'd128, 8'd254, 1'b0);
      queue_triangle(0, 0, 0, 8'd0, 8'd0, 8'd1, 1'b0);
      queue_triangle(0, 1, 3, 8'd17, 8'd0, 8'd0, 1'b0);
      queue_triangle(4095, 12'hAAA, 12'h555, 8'd0, 8'd255, 8'd0, 1'b0);
      queue_triangle(12'hAAA, 4095, 0, 8'd85, 8'd170, 8'd3, 1'b0);
      queue_triangle(12'h555, 4095, 7, 8'd200, 8'd100, 8'd50, 1'b0);
      queue_triangle(7, 12'hAAA, 1, 8'd0, 8'd0, 8'd0, 1'b0);
      queue_triangle(2, 2, 0, 8'd254, 8'd1, 8'd127, 1'b0);
      // random: mostly triangles over loaded slots, with loads mixed in
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         drain = (k == 700) || (k == 1500);
         if ($urandom_range(99) < 30) begin
            queue_load($urandom_range(VERTEX_SLOTS - 1), pick_coord(), pick_coord(),
                       pick_coord(), drain);
         end else begin
            ca = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
            cb = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
            cc = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
            // sometimes a repeated corner to force a flat triangle
            if ($urandom_range(19) == 0) cc = ca;
            r  = pick_tint();
            g  = pick_tint();
            bl = pick_tint();
            if ($urandom_range(9) == 0) begin
               r  = 8'd0;
               g  = 8'd0;
               bl = 8'd0;
            end
            queue_triangle(ca, cb, cc, r, g, bl, drain);
         end
      end
   endtask

   function automatic int idle_pct(bit sender);
      int phase;
      phase = items_in * 3 / total_items;
      if (phase == 0) return sender ? 8 : 50;
      if (phase == 1) return sender ? 50 : 8;
      return 0;
   endfunction

   // driver: predicts each accepted transaction, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            items_in++;
            if (req_chan.payload.command == CMD_LOAD) begin
               loads_in++;
               vertex_mem[req_chan.payload.load_slot] <= '{req_chan.payload.pos_x,
                  req_chan.payload.pos_y, req_chan.payload.pos_z};
            end else begin
               triangles_in++;
               expected_faces.push_back(shade_triangle(
                  vertex_mem[req_chan.payload.corner_a],
                  vertex_mem[req_chan.payload.corner_b],
                  vertex_mem[req_chan.payload.corner_c],
                  req_chan.payload.tint_red, req_chan.payload.tint_green,
                  req_chan.payload.tint_blue));
            end
         end
         if (!req_chan.valid || req_chan.ready) begin
            // a drain mark holds the item back until every response is in
            if (pending.size() != 0
                && !(pending[0].drain_first && expected_faces.size() != 0)
                && $urandom_range(99) >= idle_pct(1'b1)) begin
               req_chan.payload <= pending[0].item;
               req_chan.valid   <= 1'b1;
               void'(pending.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // a load updates the store at the edge it is taken, so a triangle in the
   // very next transaction sees it: the nonblocking write above lands before
   // the following edge

   // receiver: random back-pressure plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 0;
         long_hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!long_hold_done && triangles_in >= 60) begin
         hold_left      <= LONG_HOLD;
         long_hold_done <= 1'b1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= $urandom_range(99) >= idle_pct(1'b0);
      end
   end

   // monitor: compare each response with the oldest expectation
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         faces_out++;
         if (expected_faces.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: normal %0d %0d %0d", got.normal_x,
                        got.normal_y, got.normal_z);
         end else begin
            want = expected_faces.pop_front();
            if (want.degenerate) degenerate_out++;
            if (want.albedo_red == ALB_DEFAULT_R && want.albedo_blue == ALB_DEFAULT_B)
               default_albedo_out++;
            if (got.albedo_red !== want.albedo_red || got.albedo_green !== want.albedo_green
                || got.albedo_blue !== want.albedo_blue || got.normal_x !== want.normal_x
                || got.normal_y !== want.normal_y || got.normal_z !== want.normal_z
                || got.degenerate !== want.degenerate) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at response %0d", faces_out);
                  $display("  expected albedo %0d %0d %0d normal %0d %0d %0d degen %0b",
                           want.albedo_red, want.albedo_green, want.albedo_blue,
                           want.normal_x, want.normal_y, want.normal_z, want.degenerate);
                  $display("  actual   albedo %0d %0d %0d normal %0d %0d %0d degen %0b",
                           got.albedo_red, got.albedo_green, got.albedo_blue,
                           got.normal_x, got.normal_y, got.normal_z, got.degenerate);
               end
            end
         end
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready)
          || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("testbench NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // sequence: build stimulus, wait for it to drain, report
   initial begin
      items_in = 0; loads_in = 0; triangles_in = 0; faces_out = 0;
      degenerate_out = 0; default_albedo_out = 0; mismatches = 0; idle_cycles = 0;
      build_stimulus();
      total_items = pending.size();
      @(negedge reset);
      while (pending.size() != 0 || req_chan.valid) @(posedge clock);
      while (expected_faces.size() != 0) @(posedge clock);
      // a stray response would show up within one triangle time
      repeat (300) @(posedge clock);
      $display("covered %0d loads and %0d triangles, %0d responses checked", loads_in,
               triangles_in, faces_out);
      $display("%0d degenerate normals, %0d default albedo, %0d mismatches",
               degenerate_out, default_albedo_out, mismatches);
      if (mismatches == 0 && expected_faces.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== triangle_face_normal_albedo.f =====
hw/rtl/tfn_pkg.sv
hw/rtl/tfn_if.sv
hw/rtl/tfn_front.sv
hw/rtl/tfn_queue.sv
hw/rtl/tfn_back.sv
hw/rtl/triangle_face_normal_albedo.sv
sim/testbench.sv
